@@ hw/rtl/aeskd_pkg.sv @@
// Shared types, tables and byte functions for the AES-128 key derivation pipeline.
`timescale 1ns / 1ps
package aeskd_pkg;

  localparam int NumRounds = 10;

  typedef logic [127:0] blk_t;

  // Values carried beside the cipher state through every stage.
  typedef struct packed {
    logic        func;
    logic [63:0] rrx;
    logic [63:0] eks_hi;
    logic [63:0] eks_lo;
  } side_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a block, byte 0 being the most significant.
  function automatic logic [7:0] get_byte(input blk_t b, input logic [3:0] i);
    get_byte = b[8'd127 - {i, 3'b000} -: 8];
  endfunction

endpackage

@@ hw/rtl/aeskd_round.sv @@
// One registered AES-128 round with its round-key expansion step.
`timescale 1ns / 1ps
module aeskd_round
  import aeskd_pkg::*;
#(
  parameter int RoundIdx = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_ready,
  input  blk_t  up_state,
  input  blk_t  up_rk,
  input  side_t up_side,
  output logic  dn_valid,
  input  logic  dn_ready,
  output blk_t  dn_state,
  output blk_t  dn_rk,
  output side_t dn_side
);

  localparam bit IsLast = (RoundIdx == NumRounds - 1);

  logic [7:0] st [16];
  logic [7:0] rk [16];
  logic [7:0] sr [16];
  logic [7:0] mc [16];
  logic [7:0] nk [16];
  blk_t       state_next;
  blk_t       rk_next;
  side_t      side_q;
  logic       valid;
  blk_t       state_q;
  blk_t       rk_q;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      st[i] = get_byte(up_state, 4'(i));
      rk[i] = get_byte(up_rk, 4'(i));
    end
    // Sub bytes merged with the row shift.
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[r + 4 * c] = SBOX[st[r + 4 * ((c + r) & 3)]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] all;
      all = sr[4*c] ^ sr[4*c+1] ^ sr[4*c+2] ^ sr[4*c+3];
      mc[4*c]   = sr[4*c]   ^ all ^ xtime(sr[4*c]   ^ sr[4*c+1]);
      mc[4*c+1] = sr[4*c+1] ^ all ^ xtime(sr[4*c+1] ^ sr[4*c+2]);
      mc[4*c+2] = sr[4*c+2] ^ all ^ xtime(sr[4*c+2] ^ sr[4*c+3]);
      mc[4*c+3] = sr[4*c+3] ^ all ^ xtime(sr[4*c+3] ^ sr[4*c]);
    end
    nk[0] = rk[0] ^ SBOX[rk[13]] ^ RCON[RoundIdx];
    nk[1] = rk[1] ^ SBOX[rk[14]];
    nk[2] = rk[2] ^ SBOX[rk[15]];
    nk[3] = rk[3] ^ SBOX[rk[12]];
    for (int i = 4; i < 16; i++) begin
      nk[i] = rk[i] ^ nk[i - 4];
    end
    for (int i = 0; i < 16; i++) begin
      rk_next[127 - 8*i -: 8]    = nk[i];
      state_next[127 - 8*i -: 8] = (IsLast ? sr[i] : mc[i]) ^ nk[i];
    end
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      state_q <= state_next;
      rk_q    <= rk_next;
      side_q  <= up_side;
    end
  end

  assign dn_valid = valid;
  assign dn_state = state_q;
  assign dn_rk    = rk_q;
  assign dn_side  = side_q;

endmodule

@@ hw/rtl/aes128_session_key_derivation_top.sv @@
// Top level of the AES-128 key derivation pipeline with session key recovery.
// Throughput: one item per cycle while the output is not stalled; eleven AES stages plus one output register.
// Each stage holds its item while the stage behind it is full and stalled.
// Reset (rst, synchronous) clears all stage valid bits; payload is not reset.
`timescale 1ns / 1ps
module aes128_session_key_derivation_top
  import aeskd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [63:0] km_hi,
  input  logic [63:0] km_lo,
  input  logic [63:0] rtx,
  input  logic [63:0] rrx,
  input  logic [63:0] rn,
  input  logic [63:0] ctr,
  input  logic [63:0] eks_hi,
  input  logic [63:0] eks_lo,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] key_hi,
  output logic [63:0] key_lo
);

  // Stage 0 registers the whitened block and the cipher key. Stages 1 to 10
  // are the AES rounds, each expanding its own round key from the previous
  // one, so no key schedule memory is needed. The last stage registers the
  // result after the optional session key unmasking.
  logic  v     [NumRounds + 1];
  logic  rdy   [NumRounds + 1];
  blk_t  state [NumRounds + 1];
  blk_t  rk    [NumRounds + 1];
  side_t side  [NumRounds + 1];

  blk_t  key_in;
  blk_t  res;
  logic  in_ready;
  logic  out_ready;
  logic  ovalid;
  logic [63:0] ohi;
  logic [63:0] olo;

  assign key_in   = {km_hi, km_lo ^ rn};
  assign in_ready = !v[0] || rdy[0];
  assign in_stall = !in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (in_ready) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      state[0] <= {rtx, rrx ^ ctr} ^ key_in;
      rk[0]    <= key_in;
      side[0]  <= '{func: func, rrx: rrx, eks_hi: eks_hi, eks_lo: eks_lo};
    end
  end

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    aeskd_round #(.RoundIdx(g)) u_round (
      .clk      (clk),
      .rst      (rst),
      .up_valid (v[g]),
      .up_ready (rdy[g]),
      .up_state (state[g]),
      .up_rk    (rk[g]),
      .up_side  (side[g]),
      .dn_valid (v[g+1]),
      .dn_ready (rdy[g+1]),
      .dn_state (state[g+1]),
      .dn_rk    (rk[g+1]),
      .dn_side  (side[g+1])
    );
  end

  // In session key mode the low half is unmasked with rrx and the whole
  // block with eks.
  always_comb begin
    res = state[NumRounds];
    if (side[NumRounds].func) begin
      res = res ^ {side[NumRounds].eks_hi,
                   side[NumRounds].eks_lo ^ side[NumRounds].rrx};
    end
  end

  // The final round key is not used past the last round.
  assign out_ready      = !ovalid || !out_stall;
  assign rdy[NumRounds] = out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (out_ready) begin
      ovalid <= v[NumRounds];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && v[NumRounds]) begin
      ohi <= res[127:64];
      olo <= res[63:0];
    end
  end

  assign out_valid = ovalid;
  assign key_hi    = ohi;
  assign key_lo    = olo;

`ifndef SYNTHESIS
  // The input only stalls when the output holds a result that is stalled.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled output");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !v[0])
    else $error("pipeline not empty after reset");

  // An item in the last round moves to the output when the output is free.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (v[NumRounds] && !out_valid) |=> out_valid)
    else $error("finished item did not reach the output");
`endif

endmodule
